FILE: rtl/core/aromatic_ring_axis_assert.svh
// Assertion macros for the aromatic ring axis block.
// Each macro takes a label, an antecedent and a consequent, sampled on clk
// and quiet while rst_n is low.
`ifndef AROMATIC_RING_AXIS_ASSERT_SVH
`define AROMATIC_RING_AXIS_ASSERT_SVH
`ifndef SYNTHESIS
`define ARAX_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ARAX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ARAX_ASSERT_IMPL(label, ante, cons)
`define ARAX_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/core/arax_pkg.sv
package arax_pkg;

  localparam int COORD_W    = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int MAG_W      = PROD_W;
  localparam int RED_W      = 31;
  localparam int SQ_W       = 2 * RED_W;
  localparam int SUM_W      = 64;
  localparam int ROOT_W     = 32;
  localparam int FRAC_W     = 14;
  localparam int QUO_W      = FRAC_W + 1;
  localparam int NUM_W      = RED_W + FRAC_W + 2;
  localparam int AXIS_W     = 16;
  localparam int COUNT_W    = 4;
  localparam int SQRT_STEPS = SUM_W / 2;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_NONE  = 2'd1;
  localparam logic [1:0] STATUS_DEGEN = 2'd2;

  typedef struct packed {
    logic [1:0]                  status;
    logic [2:0][DIFF_W-1:0]      d1;
    logic [2:0][DIFF_W-1:0]      d2;
  } front_item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic                   flip;
    logic [2:0]             neg;
    logic [2:0][RED_W-1:0]  m;
  } carry_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [2:0][AXIS_W-1:0]  axis;
  } result_t;

endpackage

FILE: rtl/core/arax_front.sv
module arax_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic signed [arax_pkg::COORD_W-1:0] cx_i,
  input  logic signed [arax_pkg::COORD_W-1:0] cy_i,
  input  logic signed [arax_pkg::COORD_W-1:0] cz_i,
  input  logic signed [arax_pkg::COORD_W-1:0] ax_i,
  input  logic signed [arax_pkg::COORD_W-1:0] ay_i,
  input  logic signed [arax_pkg::COORD_W-1:0] az_i,
  input  logic signed [arax_pkg::COORD_W-1:0] bx_i,
  input  logic signed [arax_pkg::COORD_W-1:0] by_i,
  input  logic signed [arax_pkg::COORD_W-1:0] bz_i,
  input  logic [arax_pkg::COUNT_W-1:0]  count_i,
  output logic                          valid_o,
  output arax_pkg::front_item_t         item_o,
  input  logic                          q_full_i
);
  import arax_pkg::*;

  logic        valid_r;
  front_item_t item_r;
  front_item_t item_nxt;
  logic        accept;

  assign full_o  = valid_r & q_full_i;
  assign accept  = push_i & ~full_o;
  assign valid_o = valid_r;
  assign item_o  = item_r;

  // Classify by neighbor count and form both bond vectors.
  always_comb begin
    if (count_i == '0) begin
      item_nxt.status = STATUS_NONE;
    end else if (count_i == COUNT_W'(1)) begin
      item_nxt.status = STATUS_DEGEN;
    end else begin
      item_nxt.status = STATUS_OK;
    end
    item_nxt.d1[0] = DIFF_W'(ax_i) - DIFF_W'(cx_i);
    item_nxt.d1[1] = DIFF_W'(ay_i) - DIFF_W'(cy_i);
    item_nxt.d1[2] = DIFF_W'(az_i) - DIFF_W'(cz_i);
    item_nxt.d2[0] = DIFF_W'(bx_i) - DIFF_W'(cx_i);
    item_nxt.d2[1] = DIFF_W'(by_i) - DIFF_W'(cy_i);
    item_nxt.d2[2] = DIFF_W'(bz_i) - DIFF_W'(cz_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (!q_full_i) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: rtl/core/arax_queue.sv
module arax_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_i,
  input  arax_pkg::front_item_t data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output arax_pkg::front_item_t data_o
);
  import arax_pkg::*;

  front_item_t       mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r;
  logic [QPTR_W-1:0] rptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign valid_o = (cnt_r != '0);
  assign data_o  = mem_r[rptr_r];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_r <= rptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= data_i;
    end
  end

endmodule

FILE: rtl/core/arax_back.sv
module arax_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid_i,
  input  arax_pkg::front_item_t head_i,
  output logic                  head_pop_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output arax_pkg::result_t     data_o
);
  import arax_pkg::*;

  logic adv;

  // Cross product partial products.
  logic                     v1_r;
  logic [1:0]               st1_r;
  logic [2:0][PROD_W-1:0]   pa_r;
  logic [2:0][PROD_W-1:0]   pb_r;
  // Signed cross product split into sign and magnitude.
  logic                     v2_r;
  logic [1:0]               st2_r;
  logic [2:0]               neg2_r;
  logic [2:0][MAG_W-1:0]    mag2_r;
  // Reduced magnitudes.
  logic                     v3_r;
  carry_t                   c3_r;
  carry_t                   c3_nxt;
  // Squares.
  logic                     v4_r;
  carry_t                   c4_r;
  logic [2:0][SQ_W-1:0]     sq4_r;
  // Sums.
  logic                     v5_r;
  carry_t                   c5_r;
  logic [SUM_W-1:0]         sq5_r;
  logic [SUM_W-1:0]         pos5_r;
  logic [SUM_W-1:0]         neg5_r;
  // Square root pipeline.
  logic                     sv_r   [SQRT_STEPS];
  carry_t                   sc_r   [SQRT_STEPS];
  logic [SUM_W-1:0]         sx_r   [SQRT_STEPS];
  logic [SUM_W-1:0]         sres_r [SQRT_STEPS];
  logic                     sv_nxt [SQRT_STEPS];
  carry_t                   sc_nxt [SQRT_STEPS];
  logic [SUM_W-1:0]         sx_nxt [SQRT_STEPS];
  logic [SUM_W-1:0]         sres_nxt [SQRT_STEPS];
  // Division setup.
  logic                     dv0_r;
  carry_t                   dc0_r;
  logic [ROOT_W-1:0]        dn0_r;
  logic [2:0][NUM_W-1:0]    drem0_r;
  logic [ROOT_W-1:0]        norm;
  // Division pipeline.
  logic                     dv_r   [QUO_W];
  carry_t                   dc_r   [QUO_W];
  logic [ROOT_W-1:0]        dn_r   [QUO_W];
  logic [2:0][NUM_W-1:0]    drem_r [QUO_W];
  logic [2:0][QUO_W-1:0]    dq_r   [QUO_W];
  logic                     dv_nxt [QUO_W];
  carry_t                   dc_nxt [QUO_W];
  logic [ROOT_W-1:0]        dn_nxt [QUO_W];
  logic [2:0][NUM_W-1:0]    drem_nxt [QUO_W];
  logic [2:0][QUO_W-1:0]    dq_nxt [QUO_W];
  // Output queue.
  result_t                  res_nxt;
  result_t                  omem_r [2];
  logic                     owptr_r;
  logic                     orptr_r;
  logic [1:0]               ocnt_r;
  logic                     opush;
  logic                     opop;

  assign adv        = (ocnt_r != 2'd2);
  assign head_pop_o = adv & head_valid_i;
  assign norm       = sres_r[SQRT_STEPS-1][ROOT_W-1:0];

  // Stage 1: six products.
  always_ff @(posedge clk) begin
    if (adv) begin
      st1_r   <= head_i.status;
      pa_r[0] <= PROD_W'($signed(head_i.d1[1])) * PROD_W'($signed(head_i.d2[2]));
      pb_r[0] <= PROD_W'($signed(head_i.d1[2])) * PROD_W'($signed(head_i.d2[1]));
      pa_r[1] <= PROD_W'($signed(head_i.d1[2])) * PROD_W'($signed(head_i.d2[0]));
      pb_r[1] <= PROD_W'($signed(head_i.d1[0])) * PROD_W'($signed(head_i.d2[2]));
      pa_r[2] <= PROD_W'($signed(head_i.d1[0])) * PROD_W'($signed(head_i.d2[1]));
      pb_r[2] <= PROD_W'($signed(head_i.d1[1])) * PROD_W'($signed(head_i.d2[0]));
    end
  end

  // Stage 2: differences of products, kept as sign and magnitude.
  always_ff @(posedge clk) begin
    logic [CROSS_W-1:0] n;
    if (adv) begin
      st2_r <= st1_r;
      for (int i = 0; i < 3; i++) begin
        n = CROSS_W'($signed(pa_r[i])) - CROSS_W'($signed(pb_r[i]));
        neg2_r[i] <= n[CROSS_W-1];
        mag2_r[i] <= n[CROSS_W-1] ? MAG_W'(-n) : MAG_W'(n);
      end
    end
  end

  // Stage 3: collinear check and common shift until all fit in 31 bits.
  always_comb begin
    logic [MAG_W-1:0] orv;
    logic [1:0]       sh;
    orv = mag2_r[0] | mag2_r[1] | mag2_r[2];
    priority if (orv[MAG_W-1]) begin
      sh = 2'd3;
    end else if (orv[MAG_W-2]) begin
      sh = 2'd2;
    end else if (orv[MAG_W-3]) begin
      sh = 2'd1;
    end else begin
      sh = 2'd0;
    end
    c3_nxt.status = st2_r;
    if (st2_r == STATUS_OK && orv == '0) begin
      c3_nxt.status = STATUS_DEGEN;
    end
    c3_nxt.flip = 1'b0;
    c3_nxt.neg  = neg2_r;
    for (int i = 0; i < 3; i++) begin
      c3_nxt.m[i] = RED_W'(mag2_r[i] >> sh);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c3_r <= c3_nxt;
      // Stage 4: squares.
      c4_r <= c3_r;
      for (int i = 0; i < 3; i++) begin
        sq4_r[i] <= SQ_W'(c3_r.m[i]) * SQ_W'(c3_r.m[i]);
      end
    end
  end

  // Stage 5: total and signed partial sums.
  always_ff @(posedge clk) begin
    logic [SUM_W-1:0] p;
    logic [SUM_W-1:0] q;
    if (adv) begin
      p = '0;
      q = '0;
      for (int i = 0; i < 3; i++) begin
        if (c4_r.neg[i]) begin
          q = q + SUM_W'(sq4_r[i]);
        end else begin
          p = p + SUM_W'(sq4_r[i]);
        end
      end
      c5_r   <= c4_r;
      pos5_r <= p;
      neg5_r <= q;
      sq5_r  <= SUM_W'(sq4_r[0]) + SUM_W'(sq4_r[1]) + SUM_W'(sq4_r[2]);
    end
  end

  // Square root, one result bit per stage.
  always_comb begin
    logic [SUM_W-1:0] xi;
    logic [SUM_W-1:0] ri;
    logic [SUM_W-1:0] probe;
    logic [SUM_W-1:0] trial;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      if (k == 0) begin
        xi             = sq5_r;
        ri             = '0;
        sv_nxt[k]      = v5_r;
        sc_nxt[k]      = c5_r;
        sc_nxt[k].flip = (neg5_r > pos5_r);
      end else begin
        xi        = sx_r[k-1];
        ri        = sres_r[k-1];
        sv_nxt[k] = sv_r[k-1];
        sc_nxt[k] = sc_r[k-1];
      end
      probe = SUM_W'(1) << (SUM_W - 2 - 2 * k);
      trial = ri + probe;
      if (xi >= trial) begin
        sx_nxt[k]   = xi - trial;
        sres_nxt[k] = (ri >> 1) + probe;
      end else begin
        sx_nxt[k]   = xi;
        sres_nxt[k] = ri >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
        sc_r[k]   <= sc_nxt[k];
        sx_r[k]   <= sx_nxt[k];
        sres_r[k] <= sres_nxt[k];
      end
      dc0_r <= sc_r[SQRT_STEPS-1];
      dn0_r <= norm;
      for (int i = 0; i < 3; i++) begin
        drem0_r[i] <= {2'b00, sc_r[SQRT_STEPS-1].m[i], FRAC_W'(0)} + NUM_W'(norm >> 1);
      end
    end
  end

  // Restoring division, one quotient bit per stage.
  always_comb begin
    logic [2:0][NUM_W-1:0] ri;
    logic [2:0][QUO_W-1:0] qi;
    logic [NUM_W-1:0]      dsh;
    for (int k = 0; k < QUO_W; k++) begin
      if (k == 0) begin
        dv_nxt[k] = dv0_r;
        dc_nxt[k] = dc0_r;
        dn_nxt[k] = dn0_r;
        ri        = drem0_r;
        qi        = '0;
      end else begin
        dv_nxt[k] = dv_r[k-1];
        dc_nxt[k] = dc_r[k-1];
        dn_nxt[k] = dn_r[k-1];
        ri        = drem_r[k-1];
        qi        = dq_r[k-1];
      end
      dsh = NUM_W'(dn_nxt[k]) << (QUO_W - 1 - k);
      for (int i = 0; i < 3; i++) begin
        if (ri[i] >= dsh) begin
          drem_nxt[k][i]             = ri[i] - dsh;
          dq_nxt[k][i]               = qi[i];
          dq_nxt[k][i][QUO_W - 1 - k] = 1'b1;
        end else begin
          drem_nxt[k][i] = ri[i];
          dq_nxt[k][i]   = qi[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < QUO_W; k++) begin
        dc_r[k]   <= dc_nxt[k];
        dn_r[k]   <= dn_nxt[k];
        drem_r[k] <= drem_nxt[k];
        dq_r[k]   <= dq_nxt[k];
      end
    end
  end

  // Valid bits of the whole pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      dv0_r <= 1'b0;
      for (int k = 0; k < SQRT_STEPS; k++) begin
        sv_r[k] <= 1'b0;
      end
      for (int k = 0; k < QUO_W; k++) begin
        dv_r[k] <= 1'b0;
      end
    end else if (adv) begin
      v1_r  <= head_valid_i;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      dv0_r <= sv_r[SQRT_STEPS-1];
      for (int k = 0; k < SQRT_STEPS; k++) begin
        sv_r[k] <= sv_nxt[k];
      end
      for (int k = 0; k < QUO_W; k++) begin
        dv_r[k] <= dv_nxt[k];
      end
    end
  end

  // Sign, orientation flip and special cases.
  always_comb begin
    logic [AXIS_W-1:0] mg;
    res_nxt.status = dc_r[QUO_W-1].status;
    for (int i = 0; i < 3; i++) begin
      mg = AXIS_W'(dq_r[QUO_W-1][i]);
      if (dc_r[QUO_W-1].status != STATUS_OK) begin
        res_nxt.axis[i] = '0;
      end else if (dc_r[QUO_W-1].neg[i] ^ dc_r[QUO_W-1].flip) begin
        res_nxt.axis[i] = -mg;
      end else begin
        res_nxt.axis[i] = mg;
      end
    end
  end

  assign opush   = adv & dv_r[QUO_W-1];
  assign opop    = pop_i & ~empty_o;
  assign empty_o = (ocnt_r == 2'd0);
  assign data_o  = omem_r[orptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owptr_r <= 1'b0;
      orptr_r <= 1'b0;
      ocnt_r  <= 2'd0;
    end else begin
      if (opush) begin
        owptr_r <= ~owptr_r;
      end
      if (opop) begin
        orptr_r <= ~orptr_r;
      end
      if (opush && !opop) begin
        ocnt_r <= ocnt_r + 2'd1;
      end else if (opop && !opush) begin
        ocnt_r <= ocnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (opush) begin
      omem_r[owptr_r] <= res_nxt;
    end
  end

endmodule

FILE: rtl/core/aromatic_ring_axis.sv
// Throughput: one item per cycle while the output queue has room, set by a fully
// pipelined square root (32 stages) and three pipelined restoring dividers
// (15 stages each).
// Reset: rst_n is synchronous and active low; it empties every queue and clears
// all valid bits, and no clearing pass follows.
module aromatic_ring_axis (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [arax_pkg::COORD_W-1:0] in_center_x,
  input  logic signed [arax_pkg::COORD_W-1:0] in_center_y,
  input  logic signed [arax_pkg::COORD_W-1:0] in_center_z,
  input  logic signed [arax_pkg::COORD_W-1:0] in_first_x,
  input  logic signed [arax_pkg::COORD_W-1:0] in_first_y,
  input  logic signed [arax_pkg::COORD_W-1:0] in_first_z,
  input  logic signed [arax_pkg::COORD_W-1:0] in_second_x,
  input  logic signed [arax_pkg::COORD_W-1:0] in_second_y,
  input  logic signed [arax_pkg::COORD_W-1:0] in_second_z,
  input  logic [arax_pkg::COUNT_W-1:0]        in_aromatic_count,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [arax_pkg::AXIS_W-1:0]  out_axis_x,
  output logic signed [arax_pkg::AXIS_W-1:0]  out_axis_y,
  output logic signed [arax_pkg::AXIS_W-1:0]  out_axis_z,
  output logic [1:0]                          out_status
);
  import arax_pkg::*;

`include "aromatic_ring_axis_assert.svh"

  // The front stage registers each transfer, classifies it by neighbor count
  // and forms the two bond vectors.
  logic        f_valid;
  front_item_t f_item;
  // The short queue lets the front keep taking items while the back stalls.
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  front_item_t q_head;
  result_t     res;

  arax_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (in_push),
    .full_o   (in_full),
    .cx_i     (in_center_x),
    .cy_i     (in_center_y),
    .cz_i     (in_center_z),
    .ax_i     (in_first_x),
    .ay_i     (in_first_y),
    .az_i     (in_first_z),
    .bx_i     (in_second_x),
    .by_i     (in_second_y),
    .bz_i     (in_second_z),
    .count_i  (in_aromatic_count),
    .valid_o  (f_valid),
    .item_o   (f_item),
    .q_full_i (q_full)
  );

  arax_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (f_valid),
    .data_i  (f_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_head)
  );

  // The back computes the cross product, its norm and the three quotients.
  // The whole pipeline advances together whenever its two-entry output queue
  // has room, so a stalled consumer freezes it without losing an item.
  arax_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid_i (q_valid),
    .head_i       (q_head),
    .head_pop_o   (q_pop),
    .empty_o      (out_empty),
    .pop_i        (out_pop),
    .data_o       (res)
  );

  assign out_axis_x = res.axis[0];
  assign out_axis_y = res.axis[1];
  assign out_axis_z = res.axis[2];
  assign out_status = res.status;

  // A result without a valid axis carries a zero vector.
  `ARAX_ASSERT_IMPL(a_special_zero, (!out_empty && out_status != STATUS_OK), (out_axis_x == '0 && out_axis_y == '0 && out_axis_z == '0))
  // A valid axis is never the zero vector.
  `ARAX_ASSERT_IMPL(a_ok_nonzero, (!out_empty && out_status == STATUS_OK), (out_axis_x != '0 || out_axis_y != '0 || out_axis_z != '0))
  // The back only takes items the middle queue really holds.
  `ARAX_ASSERT_IMPL(a_pop_has_data, (q_pop), (q_valid))

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

// Scoreboard for the ring axis block. It computes the expected unit normal
// for every accepted input transfer and checks result transfers in order.
class axis_scoreboard;
  typedef struct {
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;
    logic [1:0]  st;
  } axis_result_t;

  axis_result_t pending_axes[$];
  int unsigned  error_count;

  function longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function void note_atom(logic signed [15:0] c[3], logic signed [15:0] a[3],
                          logic signed [15:0] b[3], logic [3:0] cnt);
    axis_result_t r;
    longint d1[3], d2[3], n[3];
    longint unsigned m[3], s, pos_sum, neg_sum, sq, norm, q, v;
    bit flip, neg;
    r.ax = 0;
    r.ay = 0;
    r.az = 0;
    pos_sum = 0;
    neg_sum = 0;
    sq = 0;
    if (cnt == 0) begin
      r.st = arax_pkg::STATUS_NONE;
    end else if (cnt == 1) begin
      r.st = arax_pkg::STATUS_DEGEN;
    end else begin
      for (int i = 0; i < 3; i++) begin
        d1[i] = longint'(a[i]) - longint'(c[i]);
        d2[i] = longint'(b[i]) - longint'(c[i]);
      end
      n[0] = d1[1] * d2[2] - d1[2] * d2[1];
      n[1] = d1[2] * d2[0] - d1[0] * d2[2];
      n[2] = d1[0] * d2[1] - d1[1] * d2[0];
      for (int i = 0; i < 3; i++) m[i] = n[i] < 0 ? -n[i] : n[i];
      if ((m[0] | m[1] | m[2]) == 0) begin
        r.st = arax_pkg::STATUS_DEGEN;
      end else begin
        // Scale all magnitudes together until each fits in 31 bits.
        while ((m[0] | m[1] | m[2]) >= (64'd1 << 31)) begin
          for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        for (int i = 0; i < 3; i++) begin
          s = m[i] * m[i];
          sq += s;
          if (n[i] < 0) neg_sum += s;
          else pos_sum += s;
        end
        flip = neg_sum > pos_sum;
        norm = int_sqrt(sq);
        for (int i = 0; i < 3; i++) begin
          q = ((m[i] << 14) + (norm >> 1)) / norm;
          neg = (n[i] < 0) != flip;
          v = neg ? -q : q;
          if (i == 0) r.ax = v[15:0];
          else if (i == 1) r.ay = v[15:0];
          else r.az = v[15:0];
        end
        r.st = arax_pkg::STATUS_OK;
      end
    end
    pending_axes.push_back(r);
  endfunction

  function void check_result(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                             logic [1:0] st);
    axis_result_t e;
    if (pending_axes.size() == 0) begin
      $error("result transfer with no expected result");
      error_count++;
      return;
    end
    e = pending_axes.pop_front();
    if (ax !== e.ax) begin
      $error("axis_x expected %0d actual %0d", $signed(e.ax), $signed(ax));
      error_count++;
    end
    if (ay !== e.ay) begin
      $error("axis_y expected %0d actual %0d", $signed(e.ay), $signed(ay));
      error_count++;
    end
    if (az !== e.az) begin
      $error("axis_z expected %0d actual %0d", $signed(e.az), $signed(az));
      error_count++;
    end
    if (st !== e.st) begin
      $error("status expected %0d actual %0d", e.st, st);
      error_count++;
    end
  endfunction
endclass

module testbench;
  localparam int PIPE_LATENCY = 56;
  localparam int RANDOM_ATOMS = 1600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic signed [15:0] in_center_x = '0, in_center_y = '0, in_center_z = '0;
  logic signed [15:0] in_first_x = '0, in_first_y = '0, in_first_z = '0;
  logic signed [15:0] in_second_x = '0, in_second_y = '0, in_second_z = '0;
  logic [3:0] in_aromatic_count = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [15:0] out_axis_x, out_axis_y, out_axis_z;
  logic [1:0] out_status;

  // The sender raises this once stimulus is done; the receiver uses the
  // quiet flags below to pick its idling mode.
  bit stimulus_done = 1'b0;
  bit quiet_phase = 1'b0;
  bit hold_receiver = 1'b0;

  axis_scoreboard board = new();

  aromatic_ring_axis i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_center_x(in_center_x), .in_center_y(in_center_y), .in_center_z(in_center_z),
    .in_first_x(in_first_x), .in_first_y(in_first_y), .in_first_z(in_first_z),
    .in_second_x(in_second_x), .in_second_y(in_second_y), .in_second_z(in_second_z),
    .in_aromatic_count(in_aromatic_count),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_axis_x(out_axis_x), .out_axis_y(out_axis_y), .out_axis_z(out_axis_z),
    .out_status(out_status)
  );

  always #6 clk = ~clk;

  // Both channels are observed at the rising edge. The expectation for an
  // input transfer is queued in the same step as the transfer itself, well
  // before its result can appear.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        board.note_atom('{in_center_x, in_center_y, in_center_z},
                        '{in_first_x, in_first_y, in_first_z},
                        '{in_second_x, in_second_y, in_second_z}, in_aromatic_count);
      end
      if (out_pop && !out_empty) begin
        board.check_result(out_axis_x, out_axis_y, out_axis_z, out_status);
      end
    end
  end

  // Offers one atom and holds it until the block takes it. The push stays
  // high into the next item unless the sender idles between items.
  task automatic send_atom(logic signed [15:0] c[3], logic signed [15:0] a[3],
                           logic signed [15:0] b[3], logic [3:0] cnt);
    while (!quiet_phase && $urandom_range(99) < 25) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    {in_center_x, in_center_y, in_center_z} <= {c[0], c[1], c[2]};
    {in_first_x, in_first_y, in_first_z} <= {a[0], a[1], a[2]};
    {in_second_x, in_second_y, in_second_z} <= {b[0], b[1], b[2]};
    in_aromatic_count <= cnt;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_coord(int mode);
    case (mode)
      0: rand_coord = 16'($urandom);
      1: rand_coord = 16'($signed($urandom_range(64)) - 32);
      default: rand_coord = $urandom_range(1) ? 16'sh7fff : -16'sh8000;
    endcase
  endfunction

  task automatic send_random_atom();
    logic signed [15:0] c[3], a[3], b[3];
    logic [3:0] cnt;
    int mode, pick;
    mode = $urandom_range(9) < 6 ? 0 : ($urandom_range(9) < 8 ? 1 : 2);
    for (int i = 0; i < 3; i++) begin
      c[i] = rand_coord(mode);
      a[i] = rand_coord(mode);
      b[i] = rand_coord(mode);
    end
    // Some atoms have collinear neighbors: the second bond is a multiple
    // of the first, so the cross product vanishes.
    if ($urandom_range(19) == 0) begin
      for (int i = 0; i < 3; i++) begin
        c[i] = rand_coord(1);
        a[i] = c[i] + rand_coord(1);
        b[i] = c[i] + 2 * (a[i] - c[i]);
      end
    end
    pick = $urandom_range(19);
    cnt = pick == 0 ? 4'd0 : (pick == 1 ? 4'd1 : 4'($urandom_range(15, 2)));
    send_atom(c, a, b, cnt);
  endtask

  // Receiver: idles at random except in a quiet stretch or once stimulus ends,
  // and holds off completely while the pressure phase is on.
  initial begin
    @(negedge clk);
    forever begin
      if (hold_receiver) out_pop <= 1'b0;
      else if (quiet_phase || stimulus_done) out_pop <= 1'b1;
      else out_pop <= ($urandom_range(99) >= 25);
      @(negedge clk);
    end
  end

  // Long receiver stall counted in cycles, while the sender keeps offering.
  initial begin
    wait (quiet_phase);
    wait (!quiet_phase);
    @(negedge clk);
    hold_receiver = 1'b1;
    repeat (300) @(negedge clk);
    hold_receiver = 1'b0;
  end

  initial begin
    logic signed [15:0] c[3], a[3], b[3];
    int drain;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed atoms: counts zero, one, two and saturated, extreme
    // coordinates, a flat ring in each plane, collinear points and the
    // orientation flip.
    c = '{16'sd0, 16'sd0, 16'sd0};
    a = '{16'sd256, 16'sd0, 16'sd0};
    b = '{16'sd0, 16'sd256, 16'sd0};
    send_atom(c, a, b, 4'd0);
    send_atom(c, a, b, 4'd1);
    send_atom(c, a, b, 4'd2);
    send_atom(c, a, b, 4'd15);
    send_atom(c, b, a, 4'd3);
    b = '{16'sd0, 16'sd0, 16'sd256};
    send_atom(c, a, b, 4'd2);
    send_atom(c, b, a, 4'd2);
    a = '{16'sd0, 16'sd256, 16'sd0};
    send_atom(c, a, b, 4'd2);
    b = '{16'sd0, 16'sd512, 16'sd0};
    send_atom(c, a, b, 4'd2);
    send_atom(c, c, c, 4'd2);
    c = '{-16'sh8000, -16'sh8000, -16'sh8000};
    a = '{16'sh7fff, -16'sh8000, 16'sh7fff};
    b = '{-16'sh8000, 16'sh7fff, 16'sh7fff};
    send_atom(c, a, b, 4'd2);
    send_atom(c, b, a, 4'd2);
    c = '{16'sh7fff, 16'sh7fff, 16'sh7fff};
    send_atom(c, a, b, 4'd2);
    a = '{-16'sh8000, 16'sh7fff, -16'sh8000};
    send_atom(c, a, b, 4'd2);
    c = '{16'sd3, -16'sd7, 16'sd11};
    a = '{-16'sd100, 16'sd5, 16'sd9};
    b = '{16'sd1, 16'sd1, -16'sd300};
    send_atom(c, a, b, 4'd7);

    // A stretch with no idling on either side.
    quiet_phase = 1'b1;
    repeat (150) send_random_atom();
    quiet_phase = 1'b0;
    // Random atoms; the receiver stall begins here and fills the block.
    repeat (RANDOM_ATOMS - 150) send_random_atom();
    in_push <= 1'b0;
    stimulus_done = 1'b1;

    drain = 0;
    while (board.pending_axes.size() != 0 && drain < 10000) begin
      @(negedge clk);
      drain++;
    end
    repeat (PIPE_LATENCY + 10) @(negedge clk);
    if (board.error_count == 0 && board.pending_axes.size() == 0) begin
      $display("testbench passed");
    end else begin
      if (board.pending_axes.size() != 0) begin
        $error("%0d expected results never arrived", board.pending_axes.size());
      end
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("testbench failed");
    $finish;
  end
endmodule
